FILE: hdl/cde_pkg.sv
// Shared types and constants for the crowding distance engine.
// Used by cde_lane, cde_merge and crowding_distance_engine; depends on nothing.
package cde_pkg;

	localparam int KEY_W        = 32;
	localparam int OBJ_SLOTS    = 4;
	localparam int MEMBER_NUM_W = 6;
	localparam int OBJ_COUNT_W  = 3;
	localparam logic [OBJ_COUNT_W-1:0] OBJ_COUNT_RESET = 3'd2;
	localparam logic [KEY_W-1:0] SIGN_FLIP = 32'h8000_0000;

	typedef enum logic [5:0] {
		ST_LOAD  = 6'b000001,
		ST_START = 6'b000010,
		ST_RANK  = 6'b000100,
		ST_DIST  = 6'b001000,
		ST_EMIT  = 6'b010000,
		ST_HOLD  = 6'b100000
	} state_t;

	typedef struct packed {
		logic clear;
		logic load_m;
		logic cmp;
		logic cmp_last;
		logic shift;
		logic div_start;
	} lane_ctl_t;

endpackage

FILE: hdl/cde_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; no package is used.
module cde_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hdl/cde_lane.sv
// One objective lane: key store, rank sort, boundary marks and a bit-serial divider.
// Depends on cde_pkg and cde_ram.
module cde_lane #(
	parameter int MAX_MEMBERS   = 64,
	parameter int FRACTION_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  cde_pkg::lane_ctl_t             ctl,
	input  logic                           wr_en,
	input  logic [$clog2(MAX_MEMBERS)-1:0] wr_addr,
	input  logic [cde_pkg::KEY_W-1:0]      wr_key,
	input  logic [$clog2(MAX_MEMBERS)-1:0] key_addr,
	input  logic                           dist_mode,
	input  logic [$clog2(MAX_MEMBERS)-1:0] ord_addr,
	input  logic [$clog2(MAX_MEMBERS)-1:0] cur_m,
	input  logic [$clog2(MAX_MEMBERS)-1:0] cmp_j,
	input  logic [$clog2(MAX_MEMBERS)-1:0] last_idx,
	input  logic [MAX_MEMBERS-1:0]         inf_all,
	output logic [MAX_MEMBERS-1:0]         bnd,
	input  logic [$clog2(MAX_MEMBERS)-1:0] sum_addr,
	output logic [FRACTION_BITS:0]         sum_data
);

	localparam int AW  = $clog2(MAX_MEMBERS);
	localparam int KW  = cde_pkg::KEY_W;
	localparam int QW  = FRACTION_BITS + 1;
	localparam int DCW = $clog2(QW + 1);

	logic [KW-1:0]  key_rdata, keym_q, lo_q, hi_q, kw0_q, kw1_q, kw2_q, range_w;
	logic [AW-1:0]  ord_rdata, key_raddr, rank_q, rank_fin, mb1_q, mb2_q, wm_q;
	logic           lt;
	logic [KW:0]    rem_q, rem_sub;
	logic           ge, skip_q;
	logic [QW-1:0]  q_q, q_next;
	logic [DCW-1:0] dcnt_q;
	logic           sum_we;
	logic [MAX_MEMBERS-1:0] bnd_q;

	assign key_raddr = dist_mode ? ord_rdata : key_addr;

	cde_ram #(.WIDTH(KW), .DEPTH(MAX_MEMBERS)) u_key_ram (
		.clk(clk), .we(wr_en), .waddr(wr_addr), .wdata(wr_key),
		.raddr(key_raddr), .rdata(key_rdata)
	);

	cde_ram #(.WIDTH(AW), .DEPTH(MAX_MEMBERS)) u_ord_ram (
		.clk(clk), .we(ctl.cmp_last), .waddr(rank_fin), .wdata(cur_m),
		.raddr(ord_addr), .rdata(ord_rdata)
	);

	cde_ram #(.WIDTH(QW), .DEPTH(MAX_MEMBERS)) u_sum_ram (
		.clk(clk), .we(sum_we), .waddr(wm_q), .wdata(skip_q ? '0 : q_next),
		.raddr(sum_addr), .rdata(sum_data)
	);

	assign lt       = (key_rdata < keym_q) || ((key_rdata == keym_q) && (cmp_j < cur_m));
	assign rank_fin = rank_q + AW'(lt);
	assign range_w  = hi_q - lo_q;
	assign ge       = rem_q >= {1'b0, range_w};
	assign rem_sub  = ge ? (rem_q - {1'b0, range_w}) : rem_q;
	assign q_next   = {q_q[QW-2:0], ge};
	assign sum_we   = (dcnt_q == DCW'(1));
	assign bnd      = bnd_q;

	always_ff @(posedge clk) begin
		if (ctl.load_m) begin
			keym_q <= key_rdata;
			rank_q <= '0;
		end else if (ctl.cmp) begin
			rank_q <= rank_fin;
		end
		if (ctl.cmp_last) begin
			if (rank_fin == '0) begin
				lo_q <= keym_q;
			end
			if (rank_fin == last_idx) begin
				hi_q <= keym_q;
			end
		end
		if (ctl.shift) begin
			kw0_q <= kw1_q;
			kw1_q <= kw2_q;
			kw2_q <= key_rdata;
			mb1_q <= mb2_q;
			mb2_q <= ord_rdata;
		end
		if (ctl.div_start) begin
			rem_q  <= {1'b0, kw2_q - kw0_q};
			skip_q <= inf_all[mb1_q] || (range_w == '0);
			wm_q   <= mb1_q;
			q_q    <= '0;
		end else if (dcnt_q != '0) begin
			rem_q <= {rem_sub[KW-1:0], 1'b0};
			q_q   <= q_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
			bnd_q  <= '0;
		end else begin
			if (ctl.div_start) begin
				dcnt_q <= DCW'(QW);
			end else if (dcnt_q != '0) begin
				dcnt_q <= dcnt_q - DCW'(1);
			end
			if (ctl.clear) begin
				bnd_q <= '0;
			end else if (ctl.cmp_last && ((rank_fin == '0) || (rank_fin == last_idx))) begin
				bnd_q[cur_m] <= 1'b1;
			end
		end
	end

endmodule

FILE: hdl/cde_merge.sv
// Merging stage: adds the per-lane distances and divides by the objective count.
// Depends on cde_pkg.
module cde_merge #(
	parameter int LANES         = 4,
	parameter int FRACTION_BITS = 16
) (
	input  logic                            clk,
	input  logic [FRACTION_BITS:0]          sums [LANES],
	input  logic [cde_pkg::OBJ_COUNT_W-1:0] obj_k,
	output logic [FRACTION_BITS:0]          avg_dist
);

	localparam int QW   = FRACTION_BITS + 1;
	localparam int SUMW = QW + 2;
	localparam int S    = SUMW + 1;
	localparam logic [S-1:0] M3 = S'(((64'd1 << S) + 64'd2) / 64'd3);

	logic [SUMW-1:0]   total;
	logic [SUMW-1:0]   sum_s1, sum_s2;
	logic [cde_pkg::OBJ_COUNT_W-1:0] k_s1, k_s2;
	logic [SUMW+S-1:0] prod_s2;
	logic [SUMW-1:0]   quo;

	always_comb begin
		total = '0;
		for (int l = 0; l < LANES; l++) begin
			if (l < int'(obj_k)) begin
				total = total + SUMW'(sums[l]);
			end
		end
	end

	always_ff @(posedge clk) begin
		sum_s1  <= total;
		k_s1    <= obj_k;
		sum_s2  <= sum_s1;
		k_s2    <= k_s1;
		prod_s2 <= (SUMW+S)'(sum_s1) * (SUMW+S)'(M3);
	end

	always_comb begin
		unique case (k_s2)
			3'd1:    quo = sum_s2;
			3'd2:    quo = sum_s2 >> 1;
			3'd3:    quo = prod_s2[SUMW+S-1:S];
			default: quo = sum_s2 >> 2;
		endcase
	end

	assign avg_dist = quo[QW-1:0];

endmodule

FILE: hdl/crowding_distance_engine.sv
// Crowding distance engine: one lane per objective sorts the front by rank counting, marks the
// boundary members and divides each neighbour gap by the objective's range bit-serially; a merging
// stage averages the lanes. Depends on cde_pkg, cde_ram, cde_lane and cde_merge.
//
// A front is loaded at one member per cycle. On the last member the lanes sort in parallel, then
// walk the sorted order through the bit-serial divider, then one result per member leaves and is
// held until m_tready. Fronts of two or fewer members skip the sort and are all marked infinite.
// A new front is taken only after the last result of the previous one has left.
module crowding_distance_engine #(
	parameter int MAX_MEMBERS    = 64,
	parameter int MAX_OBJECTIVES = 4,
	parameter int FRACTION_BITS  = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// objective_a, objective_b, objective_c, objective_d
	input  logic [cde_pkg::OBJ_SLOTS*cde_pkg::KEY_W-1:0] s_tdata,
	input  logic                                   s_tlast,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// member_number, distance, zero padding
	output logic [((cde_pkg::MEMBER_NUM_W+FRACTION_BITS+8)/8)*8-1:0] m_tdata,
	// is_infinite
	output logic                                   m_tuser,
	output logic                                   m_tlast,
	input  logic                                   cfg_we,
	input  logic [cde_pkg::OBJ_COUNT_W-1:0]        cfg_wdata
);

	localparam int AW  = $clog2(MAX_MEMBERS);
	localparam int CW  = $clog2(MAX_MEMBERS + 1);
	localparam int QW  = FRACTION_BITS + 1;
	localparam int SW  = $clog2(FRACTION_BITS + 6);
	localparam int TW  = ((cde_pkg::MEMBER_NUM_W + FRACTION_BITS + 8) / 8) * 8;
	localparam int KW  = cde_pkg::KEY_W;

	cde_pkg::state_t    state_q;
	cde_pkg::lane_ctl_t ctl, rctl, rctl_s1;
	logic [cde_pkg::OBJ_COUNT_W-1:0] cfg_q, obj_k;
	logic [CW-1:0] cnt_q, n_q;
	logic [AW-1:0] m_q, j_q, p_q, e_q, m_s1, j_s1, last_idx, rank_addr;
	logic          fetch_q;
	logic [SW-1:0] step_q, dist_end;
	logic          in_acc, store;
	logic [MAX_MEMBERS-1:0] bnd [MAX_OBJECTIVES];
	logic [MAX_MEMBERS-1:0] inf_all;
	logic [QW-1:0] sums [MAX_OBJECTIVES];
	logic [QW-1:0] merged;
	logic [AW-1:0] out_num_q;
	logic [QW-1:0] out_dist_q;
	logic          out_inf_q, out_last_q;

	assign s_tready = (state_q == cde_pkg::ST_LOAD);
	assign in_acc   = s_tvalid && s_tready;
	assign store    = in_acc && (cnt_q < CW'(MAX_MEMBERS));
	assign last_idx = AW'(n_q - CW'(1));
	assign dist_end = (p_q < AW'(2)) ? SW'(3) : SW'(FRACTION_BITS + 5);

	always_comb begin
		if (cfg_q == '0) begin
			obj_k = 3'd1;
		end else if (cfg_q > 3'(MAX_OBJECTIVES)) begin
			obj_k = 3'(MAX_OBJECTIVES);
		end else begin
			obj_k = cfg_q;
		end
	end

	always_comb begin
		rctl      = '0;
		rank_addr = fetch_q ? m_q : j_q;
		if (state_q == cde_pkg::ST_RANK) begin
			rctl.load_m   = fetch_q;
			rctl.cmp      = !fetch_q;
			rctl.cmp_last = !fetch_q && (j_q == last_idx);
		end
	end

	always_comb begin
		ctl           = rctl_s1;
		ctl.clear     = (state_q == cde_pkg::ST_START);
		ctl.shift     = (state_q == cde_pkg::ST_DIST) && (step_q == SW'(3));
		ctl.div_start = (state_q == cde_pkg::ST_DIST) && (step_q == SW'(4)) && (p_q >= AW'(2));
	end

	always_comb begin
		inf_all = '0;
		for (int l = 0; l < MAX_OBJECTIVES; l++) begin
			if (l < int'(obj_k)) begin
				inf_all = inf_all | bnd[l];
			end
		end
		if (n_q <= CW'(2)) begin
			inf_all = '1;
		end
	end

	for (genvar l = 0; l < MAX_OBJECTIVES; l++) begin : g_lane
		cde_lane #(.MAX_MEMBERS(MAX_MEMBERS), .FRACTION_BITS(FRACTION_BITS)) u_lane (
			.clk(clk), .arst_n(arst_n), .ctl(ctl),
			.wr_en(store), .wr_addr(cnt_q[AW-1:0]),
			.wr_key(s_tdata[l*KW +: KW] ^ cde_pkg::SIGN_FLIP),
			.key_addr(rank_addr), .dist_mode(state_q == cde_pkg::ST_DIST),
			.ord_addr(p_q), .cur_m(m_s1), .cmp_j(j_s1), .last_idx(last_idx),
			.inf_all(inf_all), .bnd(bnd[l]),
			.sum_addr(e_q), .sum_data(sums[l])
		);
	end

	cde_merge #(.LANES(MAX_OBJECTIVES), .FRACTION_BITS(FRACTION_BITS)) u_merge (
		.clk(clk), .sums(sums), .obj_k(obj_k), .avg_dist(merged)
	);

	always_ff @(posedge clk) begin
		m_s1 <= m_q;
		j_s1 <= j_q;
		if ((state_q == cde_pkg::ST_EMIT) && (step_q == SW'(3))) begin
			out_num_q  <= e_q;
			out_inf_q  <= inf_all[e_q];
			out_dist_q <= inf_all[e_q] ? '0 : merged;
			out_last_q <= (e_q == last_idx);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cde_pkg::ST_LOAD;
			cfg_q   <= cde_pkg::OBJ_COUNT_RESET;
			cnt_q   <= '0;
			n_q     <= '0;
			m_q     <= '0;
			j_q     <= '0;
			p_q     <= '0;
			e_q     <= '0;
			fetch_q <= 1'b0;
			step_q  <= '0;
			rctl_s1 <= '0;
		end else begin
			rctl_s1 <= rctl;
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
			end
			unique case (state_q)
				cde_pkg::ST_LOAD: begin
					if (in_acc && s_tlast) begin
						n_q     <= store ? cnt_q + CW'(1) : cnt_q;
						cnt_q   <= '0;
						state_q <= cde_pkg::ST_START;
					end else if (store) begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				cde_pkg::ST_START: begin
					m_q     <= '0;
					j_q     <= '0;
					e_q     <= '0;
					p_q     <= '0;
					step_q  <= '0;
					fetch_q <= 1'b1;
					state_q <= (n_q <= CW'(2)) ? cde_pkg::ST_EMIT : cde_pkg::ST_RANK;
				end
				cde_pkg::ST_RANK: begin
					if (fetch_q) begin
						fetch_q <= 1'b0;
						j_q     <= '0;
					end else begin
						j_q <= j_q + AW'(1);
						if (j_q == last_idx) begin
							fetch_q <= 1'b1;
							m_q     <= m_q + AW'(1);
							if (m_q == last_idx) begin
								state_q <= cde_pkg::ST_DIST;
							end
						end
					end
				end
				cde_pkg::ST_DIST: begin
					if (step_q == dist_end) begin
						step_q <= '0;
						if (p_q == last_idx) begin
							state_q <= cde_pkg::ST_EMIT;
						end else begin
							p_q <= p_q + AW'(1);
						end
					end else begin
						step_q <= step_q + SW'(1);
					end
				end
				cde_pkg::ST_EMIT: begin
					if (step_q == SW'(3)) begin
						step_q  <= '0;
						state_q <= cde_pkg::ST_HOLD;
					end else begin
						step_q <= step_q + SW'(1);
					end
				end
				cde_pkg::ST_HOLD: begin
					if (m_tready) begin
						if (e_q == last_idx) begin
							state_q <= cde_pkg::ST_LOAD;
						end else begin
							e_q     <= e_q + AW'(1);
							state_q <= cde_pkg::ST_EMIT;
						end
					end
				end
				default: state_q <= cde_pkg::ST_LOAD;
			endcase
		end
	end

	assign m_tvalid = (state_q == cde_pkg::ST_HOLD);
	assign m_tuser  = out_inf_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = TW'({out_dist_q, cde_pkg::MEMBER_NUM_W'(out_num_q)});

endmodule
